/* rtl/ffa_pkg.sv */
// Shared constants and codes of the first-fit free-list allocator.
`default_nettype none
package ffa_pkg;
	localparam int DEF_NUM_BLOCKS   = 64;
	localparam int DEF_HEADER_BYTES = 12;
	localparam int DEF_ADDR_BITS    = 32;

	localparam logic [1:0] OP_ALLOCATE = 2'd0;
	localparam logic [1:0] OP_RELEASE  = 2'd1;
	localparam logic [1:0] OP_REINIT   = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
	localparam logic [1:0] STATUS_BAD_REL = 2'd2;

	localparam logic CFG_POOL_BASE = 1'b0;
	localparam logic CFG_POOL_SIZE = 1'b1;
endpackage
`default_nettype wire

/* rtl/first_fit_free_list_allocator_core.sv */
// First-fit free-list allocator: descriptor memory, walk and release sequencer.
// Reinitialize and unused codes go straight to the output register; allocate walks the
// free list (at most NUM_BLOCKS descriptors), then writes back the split-off spare and the
// predecessor's link where needed; release scans the slots (at most NUM_BLOCKS).
// One item is worked on at a time; the descriptor memory (one read per cycle)
// sets the walk and scan rate. Reset clears the slot flags to a single free slot 0 and
// treats slot 0 as a zero-length block until it is first written; no clearing pass.
`default_nettype none
module first_fit_free_list_allocator_core
	import ffa_pkg::*;
#(
	parameter int NUM_BLOCKS   = DEF_NUM_BLOCKS,
	parameter int HEADER_BYTES = DEF_HEADER_BYTES,
	parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	// Input word channel.
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] request_size,
	input  wire logic [31:0] block_address,
	// Result word channel.
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             granted,
	output logic [31:0]      granted_address,
	output logic [1:0]       status
);
	// Slot index width and link width; a link equal to NUM_BLOCKS marks the end of a list.
	localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int LW = $clog2(NUM_BLOCKS + 1);
	localparam logic [LW-1:0] NIL = LW'(NUM_BLOCKS);
	localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_BLOCKS - 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_WALK   = 3'd1;
	localparam logic [2:0] S_WSPARE = 3'd2;
	localparam logic [2:0] S_WLINK  = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	typedef struct packed {
		logic [ADDR_BITS-1:0] base;
		logic [31:0]          len;
		logic [LW-1:0]        link;
	} desc_t;

	// Lowest slot that holds no block, and whether one exists.
	function automatic logic [IW:0] find_spare(input logic [NUM_BLOCKS-1:0] used);
		logic [IW:0] r;
		r = '0;
		for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				r = {1'b1, IW'(i)};
			end
		end
		return r;
	endfunction

	// Configuration registers; they take effect at the next reinitialize word.
	logic [31:0] pool_base_q, pool_size_q;

	// Descriptor memory with one write and one registered read per cycle.
	desc_t           desc_mem_q [NUM_BLOCKS];
	desc_t           rd_q;
	logic            rd_zero_q;
	logic            mem_we, mem_re;
	logic [IW-1:0]   mem_waddr, mem_raddr;
	desc_t           mem_wdata;
	desc_t           rd_desc;

	// Per-slot flags live in flip-flops so reset and reinitialize clear them at once.
	logic [NUM_BLOCKS-1:0] in_use_q, is_free_q;
	logic [LW-1:0]         head_q;
	// Set once slot 0 has been written since reset; until then its descriptor reads as empty.
	logic                  built_q;

	logic [2:0]  state_q;
	logic [31:0] req_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] steps_q;
	logic [IW:0]   spare_q;
	logic          prev_ok_q;
	logic [IW-1:0] prev_q;
	desc_t         prev_desc_q;
	desc_t         hit_q;
	logic [LW-1:0] next_q;

	logic        res_granted_q;
	logic [31:0] res_addr_q;
	logic [1:0]  res_status_q;
	logic        out_valid_q, granted_q;
	logic [31:0] granted_address_q;
	logic [1:0]  status_q;

	logic        accept;
	logic [33:0] threshold;
	logic        fits, do_split, walk_end, rel_match;
	logic [IW:0] spare_now;

	assign cfg_ready       = 1'b1;
	assign in_stall        = (state_q != S_IDLE);
	assign accept          = in_valid && !in_stall;
	assign out_valid       = out_valid_q;
	assign granted         = granted_q;
	assign granted_address = granted_address_q;
	assign status          = status_q;

	assign rd_desc   = rd_zero_q ? desc_t'{base: '0, len: '0, link: NIL} : rd_q;
	assign spare_now = find_spare(in_use_q);
	assign threshold = 34'(req_q) + 34'(HEADER_BYTES);
	assign fits      = (rd_desc.len >= req_q);
	assign do_split  = ({2'b00, rd_desc.len} > threshold) && spare_q[IW];
	// The walk stops at the end of the list, at a link outside the table, or after
	// visiting as many descriptors as the table holds.
	assign walk_end  = (rd_desc.link >= NIL) || (steps_q == LAST_SLOT);
	assign rel_match = in_use_q[cur_q] && !is_free_q[cur_q] && (rd_desc.base == addr_q);

	// Memory port control: which descriptor is written and which is read this cycle.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = rd_desc;
		mem_re    = 1'b0;
		mem_raddr = cur_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && operation == OP_REINIT) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = desc_t'{base: ADDR_BITS'(pool_base_q), len: pool_size_q,
						link: NIL};
				end else if (accept && operation == OP_ALLOCATE) begin
					mem_re    = 1'b1;
					mem_raddr = head_q[IW-1:0];
				end else if (accept && operation == OP_RELEASE) begin
					mem_re    = 1'b1;
					mem_raddr = '0;
				end
			end
			S_WALK: begin
				if (fits) begin
					mem_we    = 1'b1;
					mem_waddr = cur_q;
					mem_wdata = desc_t'{base: rd_desc.base,
						len: do_split ? req_q : rd_desc.len, link: NIL};
				end else begin
					mem_re    = 1'b1;
					mem_raddr = rd_desc.link[IW-1:0];
				end
			end
			S_WSPARE: begin
				mem_we    = 1'b1;
				mem_waddr = spare_q[IW-1:0];
				mem_wdata = desc_t'{base: ADDR_BITS'(hit_q.base + ADDR_BITS'(req_q)),
					len: hit_q.len - req_q, link: hit_q.link};
			end
			S_WLINK: begin
				mem_we    = prev_ok_q;
				mem_waddr = prev_q;
				mem_wdata = desc_t'{base: prev_desc_q.base, len: prev_desc_q.len,
					link: next_q};
			end
			S_SCAN: begin
				if (rel_match) begin
					mem_we    = 1'b1;
					mem_waddr = cur_q;
					mem_wdata = desc_t'{base: rd_desc.base, len: rd_desc.len, link: head_q};
				end else begin
					mem_re    = 1'b1;
					mem_raddr = IW'(cur_q + 1'b1);
				end
			end
			S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			desc_mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= desc_mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_zero_q <= 1'b0;
		end else if (mem_re) begin
			rd_zero_q <= (mem_raddr == '0) && !built_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			pool_size_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_POOL_BASE: pool_base_q <= cfg_data;
				CFG_POOL_SIZE: pool_size_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer: walk for allocate, scan for release, write-back and result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			in_use_q      <= NUM_BLOCKS'(1);
			is_free_q     <= NUM_BLOCKS'(1);
			head_q        <= '0;
			built_q       <= 1'b0;
			res_granted_q <= 1'b0;
			res_addr_q    <= '0;
			res_status_q  <= STATUS_OK;
			out_valid_q   <= 1'b0;
		end else begin
			if (mem_we && mem_waddr == '0) begin
				built_q <= 1'b1;
			end
			// A taken word empties the result register unless a new one is loaded now.
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_addr_q <= '0;
						req_q      <= request_size;
						addr_q     <= ADDR_BITS'(block_address);
						steps_q    <= '0;
						prev_ok_q  <= 1'b0;
						spare_q    <= spare_now;
						case (operation)
							OP_REINIT: begin
								in_use_q      <= NUM_BLOCKS'(1);
								is_free_q     <= NUM_BLOCKS'(1);
								head_q        <= '0;
								cur_q         <= '0;
								res_granted_q <= 1'b1;
								res_status_q  <= STATUS_OK;
								state_q       <= S_OUT;
							end
							OP_ALLOCATE: begin
								cur_q         <= head_q[IW-1:0];
								res_granted_q <= 1'b0;
								if (head_q >= NIL) begin
									res_status_q <= STATUS_NO_FIT;
									state_q      <= S_OUT;
								end else begin
									res_status_q <= STATUS_OK;
									state_q      <= S_WALK;
								end
							end
							OP_RELEASE: begin
								cur_q         <= '0;
								res_granted_q <= 1'b0;
								res_status_q  <= STATUS_OK;
								state_q       <= S_SCAN;
							end
							default: begin
								cur_q         <= '0;
								res_granted_q <= 1'b0;
								res_status_q  <= STATUS_OK;
								state_q       <= S_OUT;
							end
						endcase
					end
				end
				S_WALK: begin
					if (fits) begin
						is_free_q[cur_q] <= 1'b0;
						hit_q            <= rd_desc;
						res_granted_q    <= 1'b1;
						res_addr_q       <= 32'(rd_desc.base);
						if (do_split) begin
							in_use_q[spare_q[IW-1:0]]  <= 1'b1;
							is_free_q[spare_q[IW-1:0]] <= 1'b1;
						end
						next_q <= do_split ? LW'(spare_q[IW-1:0]) : rd_desc.link;
						if (!prev_ok_q) begin
							head_q <= do_split ? LW'(spare_q[IW-1:0]) : rd_desc.link;
						end
						state_q <= do_split ? S_WSPARE : (prev_ok_q ? S_WLINK : S_OUT);
					end else if (walk_end) begin
						res_status_q <= STATUS_NO_FIT;
						state_q      <= S_OUT;
					end else begin
						prev_ok_q   <= 1'b1;
						prev_q      <= cur_q;
						prev_desc_q <= rd_desc;
						cur_q       <= rd_desc.link[IW-1:0];
						steps_q     <= IW'(steps_q + 1'b1);
					end
				end
				S_WSPARE: begin
					state_q <= prev_ok_q ? S_WLINK : S_OUT;
				end
				S_WLINK: begin
					state_q <= S_OUT;
				end
				S_SCAN: begin
					if (rel_match) begin
						head_q           <= LW'(cur_q);
						is_free_q[cur_q] <= 1'b1;
						res_granted_q    <= 1'b1;
						state_q          <= S_OUT;
					end else if (cur_q == LAST_SLOT) begin
						res_status_q <= STATUS_BAD_REL;
						state_q      <= S_OUT;
					end else begin
						cur_q <= IW'(cur_q + 1'b1);
					end
				end
				S_OUT: begin
					// The result register frees up in the same cycle its word is taken.
					if (!out_valid_q || !out_stall) begin
						out_valid_q       <= 1'b1;
						granted_q         <= res_granted_q;
						granted_address_q <= res_addr_q;
						status_q          <= res_status_q;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* tb/sv/first_fit_free_list_allocator_core_tb.sv */
// Self-checking testbench for the first-fit free-list allocator core.
`default_nettype none
module first_fit_free_list_allocator_core_tb;
	import ffa_pkg::*;

	localparam int NBLK = DEF_NUM_BLOCKS;
	localparam int HDR = DEF_HEADER_BYTES;
	localparam int WATCHDOG = 20000;
	localparam int RANDOM_WORDS = 1400;

	// Clock, reset and the pins of the block.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_POOL_BASE;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = OP_ALLOCATE;
	logic [31:0] request_size = '0;
	logic [31:0] block_address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic granted;
	logic [31:0] granted_address;
	logic [1:0] status;

	always #2 clk = ~clk;

	first_fit_free_list_allocator_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.request_size(request_size), .block_address(block_address),
		.out_valid(out_valid), .out_stall(out_stall), .granted(granted),
		.granted_address(granted_address), .status(status)
	);

	// One result word as the allocator returns it.
	typedef struct packed {
		logic        ok;
		logic [31:0] addr;
		logic [1:0]  code;
	} grant_t;

	// Shadow copy of the descriptor table, free list and pool registers.
	logic [31:0] shadow_base [NBLK];
	logic [31:0] shadow_len [NBLK];
	int          shadow_link [NBLK];
	bit          shadow_used [NBLK];
	bit          shadow_free [NBLK];
	int          shadow_head;
	logic [31:0] pool_start;
	logic [31:0] pool_bytes;

	grant_t pending_grants [$];
	// Bases the shadow believes are currently allocated; used to aim releases.
	logic [31:0] live_blocks [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	// Rebuilds the pool as one free block, exactly as a reinitialize word does.
	function automatic void rebuild_pool();
		for (int i = 0; i < NBLK; i++) begin
			shadow_base[i] = '0;
			shadow_len[i] = '0;
			shadow_link[i] = NBLK;
			shadow_used[i] = 1'b0;
			shadow_free[i] = 1'b0;
		end
		shadow_base[0] = pool_start;
		shadow_len[0] = pool_bytes;
		shadow_used[0] = 1'b1;
		shadow_free[0] = 1'b1;
		shadow_head = 0;
		live_blocks.delete();
	endfunction

	// First fit: walk the free list, split off the tail when a header fits and a
	// descriptor is spare, and unlink the block that is handed out.
	function automatic grant_t first_fit(logic [31:0] req);
		grant_t g;
		int prev, cur, nxt, spare;
		prev = NBLK;
		cur = shadow_head;
		g = '{ok: 1'b0, addr: '0, code: STATUS_NO_FIT};
		for (int steps = 0; steps < NBLK && cur < NBLK; steps++) begin
			if (shadow_len[cur] >= req) begin
				nxt = shadow_link[cur];
				spare = NBLK;
				for (int i = NBLK - 1; i >= 0; i--)
					if (!shadow_used[i])
						spare = i;
				if ({32'd0, shadow_len[cur]} > {32'd0, req} + HDR && spare < NBLK) begin
					shadow_base[spare] = shadow_base[cur] + req;
					shadow_len[spare] = shadow_len[cur] - req;
					shadow_link[spare] = nxt;
					shadow_used[spare] = 1'b1;
					shadow_free[spare] = 1'b1;
					shadow_len[cur] = req;
					nxt = spare;
				end
				if (prev >= NBLK)
					shadow_head = nxt;
				else
					shadow_link[prev] = nxt;
				shadow_link[cur] = NBLK;
				shadow_free[cur] = 1'b0;
				live_blocks.push_back(shadow_base[cur]);
				return '{ok: 1'b1, addr: shadow_base[cur], code: STATUS_OK};
			end
			prev = cur;
			cur = shadow_link[cur];
		end
		return g;
	endfunction

	// Release pushes the lowest matching allocated slot onto the list head.
	function automatic grant_t give_back(logic [31:0] addr);
		for (int i = 0; i < NBLK; i++) begin
			if (shadow_used[i] && !shadow_free[i] && shadow_base[i] == addr) begin
				shadow_link[i] = shadow_head;
				shadow_head = i;
				shadow_free[i] = 1'b1;
				for (int k = 0; k < live_blocks.size(); k++)
					if (live_blocks[k] == addr) begin
						live_blocks.delete(k);
						break;
					end
				return '{ok: 1'b1, addr: '0, code: STATUS_OK};
			end
		end
		return '{ok: 1'b0, addr: '0, code: STATUS_BAD_REL};
	endfunction

	function automatic grant_t predict_grant(logic [1:0] op, logic [31:0] req,
			logic [31:0] addr);
		case (op)
			OP_ALLOCATE: return first_fit(req);
			OP_RELEASE: return give_back(addr);
			OP_REINIT: begin
				rebuild_pool();
				return '{ok: 1'b1, addr: '0, code: STATUS_OK};
			end
			default: return '{ok: 1'b0, addr: '0, code: STATUS_OK};
		endcase
	endfunction

	// Result side: random stall bursts, none once quiet is set.
	// Every word taken is checked against the oldest pending grant.
	int stall_left = 0;
	always @(posedge clk) begin
		grant_t want;
		if (out_valid && !out_stall && arst_n) begin
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: granted=%0b addr=%h status=%0d",
						granted, granted_address, status);
			end else begin
				want = pending_grants.pop_front();
				if (granted !== want.ok || granted_address !== want.addr ||
						status !== want.code) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %0b/%h/%0d got %0b/%h/%0d",
							want.ok, want.addr, want.code, granted, granted_address, status);
				end
			end
		end
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: counts cycles in which no word moves on any channel. A full walk
	// plus write-back stays well within the limit, so the limit is generous.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Sends one input word, with an optional random gap first, and predicts it
	// at the edge where the allocator accepts it. Valid stays high afterwards
	// until the next word or an explicit drop, so back-to-back words need only
	// one assignment per edge.
	task automatic send_word(logic [1:0] op, logic [31:0] req, logic [31:0] addr);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		request_size <= req;
		block_address <= addr;
		do @(posedge clk); while (in_stall);
		pending_grants.push_back(predict_grant(op, req, addr));
	endtask

	// Same, with the expected word typed in and compared to the prediction.
	task automatic send_known(logic [1:0] op, logic [31:0] req, logic [31:0] addr,
			grant_t known);
		send_word(op, req, addr);
		if (pending_grants[$] !== known) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row disagrees with prediction: op=%0d", op);
			pending_grants[$] = known;
		end
	endtask

	// Register writes happen only with nothing in flight; the pause lets any
	// write-back of the last word finish.
	task automatic write_pool(logic [31:0] start, logic [31:0] bytes);
		in_valid <= 1'b0;
		wait (pending_grants.size() == 0);
		repeat (2 * NBLK + 8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_POOL_BASE;
		cfg_data <= start;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_POOL_SIZE;
		cfg_data <= bytes;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pool_start = start;
		pool_bytes = bytes;
	endtask

	// Directed rows: operation, size, address, and whether the result is typed in.
	typedef struct {
		logic [1:0]  op;
		logic [31:0] req;
		logic [31:0] addr;
		bit          typed;
		grant_t      known;
	} row_t;

	localparam grant_t OK_WORD = '{ok: 1'b1, addr: 32'd0, code: STATUS_OK};
	localparam grant_t NOFIT_WORD = '{ok: 1'b0, addr: 32'd0, code: STATUS_NO_FIT};
	localparam grant_t BADREL_WORD = '{ok: 1'b0, addr: 32'd0, code: STATUS_BAD_REL};
	localparam grant_t UNUSED_WORD = '{ok: 1'b0, addr: 32'd0, code: STATUS_OK};

	row_t rows [$];

	task automatic add_row(logic [1:0] op, logic [31:0] req, logic [31:0] addr,
			bit typed, grant_t known);
		rows.push_back('{op, req, addr, typed, known});
	endtask

	initial begin
		logic [1:0] op;
		logic [31:0] req, addr;
		int pick;
		pool_start = '0;
		pool_bytes = '0;
		rebuild_pool();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset the pool is empty: only a zero-size request fits.
		add_row(OP_ALLOCATE, 32'd1, 32'd0, 1'b1, NOFIT_WORD);
		add_row(OP_ALLOCATE, 32'd0, 32'd0, 1'b1, '{ok: 1'b1, addr: 32'd0, code: STATUS_OK});
		add_row(OP_RELEASE, 32'd0, 32'd0, 1'b1, OK_WORD);
		add_row(OP_RELEASE, 32'd0, 32'd0, 1'b1, BADREL_WORD);
		add_row(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, UNUSED_WORD);
		add_row(OP_REINIT, 32'd0, 32'd0, 1'b1, OK_WORD);
		foreach (rows[i])
			send_known(rows[i].op, rows[i].req, rows[i].addr, rows[i].known);
		rows.delete();

		// Near the top of the address space, so splits wrap around zero.
		write_pool(32'hFFFF_FF00, 32'hFFFF_FFFF);
		add_row(OP_REINIT, 32'd0, 32'd0, 1'b1, OK_WORD);
		add_row(OP_ALLOCATE, 32'd0, 32'd0, 1'b1, '{ok: 1'b1, addr: 32'hFFFF_FF00,
			code: STATUS_OK});
		add_row(OP_ALLOCATE, 32'h0000_0200, 32'd0, 1'b0, OK_WORD);
		add_row(OP_ALLOCATE, 32'd12, 32'd0, 1'b0, OK_WORD);
		add_row(OP_ALLOCATE, 32'hFFFF_FFFF, 32'd0, 1'b1, NOFIT_WORD);
		add_row(OP_RELEASE, 32'd0, 32'hFFFF_FF00, 1'b0, OK_WORD);
		add_row(OP_RELEASE, 32'd0, 32'hFFFF_FF00, 1'b0, OK_WORD);
		add_row(OP_RELEASE, 32'd0, 32'h1234_5678, 1'b1, BADREL_WORD);
		add_row(OP_ALLOCATE, 32'd0, 32'd0, 1'b0, OK_WORD);
		foreach (rows[i])
			if (rows[i].typed)
				send_known(rows[i].op, rows[i].req, rows[i].addr, rows[i].known);
			else
				send_word(rows[i].op, rows[i].req, rows[i].addr);
		rows.delete();

		// Exhaust the descriptors: once no slot is spare, a fitting block is handed out whole.
		write_pool(32'h0001_0000, 32'd4000);
		send_word(OP_REINIT, 32'd0, 32'd0);
		for (int i = 0; i < NBLK + 2; i++)
			send_word(OP_ALLOCATE, 32'd20, 32'd0);
		send_word(OP_ALLOCATE, 32'd4000, 32'd0);

		// Random phases over several pool settings.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_pool($urandom, $urandom_range(200, 3000));
				1: write_pool($urandom, $urandom);
				2: write_pool(32'h0, 32'h0);
				default: write_pool(32'hFFFF_FFFF, $urandom_range(500, 9000));
			endcase
			send_word(OP_REINIT, 32'd0, 32'd0);
			for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
				if (phase == 3 && n > RANDOM_WORDS / 8)
					quiet = 1'b1;
				pick = $urandom_range(0, 99);
				op = OP_ALLOCATE;
				req = $urandom_range(0, 300);
				addr = $urandom;
				if (pick < 45) begin
					if ($urandom_range(0, 9) == 0)
						req = $urandom;
				end else if (pick < 85) begin
					op = OP_RELEASE;
					if (live_blocks.size() > 0 && $urandom_range(0, 5) != 0)
						addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
				end else if (pick < 90) begin
					op = OP_REINIT;
				end else if (pick < 93) begin
					op = 2'd3;
				end else begin
					// Double release of a free block: the base of the free-list head, or of slot 0.
					op = OP_RELEASE;
					addr = shadow_base[shadow_head < NBLK ? shadow_head : 0];
				end
				send_word(op, req, addr);
			end
		end
		in_valid <= 1'b0;

		fork
			wait (pending_grants.size() == 0);
			begin
				repeat (WATCHDOG) @(posedge clk);
			end
		join_any
		repeat (2 * NBLK + 8) @(posedge clk);
		if (mismatches == 0 && pending_grants.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
